>>> hw/rtl/arpt_pkg.sv
`default_nettype none
package arpt_pkg;

  localparam int unsigned ENTRIES_DEF  = 16;
  localparam int unsigned REQUESTS_DEF = 8;

  localparam logic [15:0] TIMEOUT_RST = 16'd30;
  localparam logic [2:0]  LIMIT_RST   = 3'd5;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_QUEUE  = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] found_mac;
    logic        pending;
    logic        table_full;
    logic        resend;
    logic [31:0] resend_ip;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic slot_step;
    logic slot_done;
    logic req_step;
    logic req_done;
    logic finish;
  } arpt_cmd_t;

  typedef struct packed {
    logic slot_end;
    logic req_end;
    logic out_free;
  } arpt_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/arp_table_with_aging_and_retry.sv
`default_nettype none
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid_i/in_stall_o  | in_word_i  (op, ip_addr, mac_addr)
// out     | output    | out_valid_o/out_stall_i| out_word_o (hit .. last)
// cfg     | input     | cfg_we_i               | cfg_addr_i, cfg_wdata_i
//
// One word at a time. Lookup walks the bindings until a hit or the end.
// Insert and queue walk the requests until a match or the end; remove walks
// all requests. Tick walks all bindings then all requests, one per cycle
// (requests only while the output is free), set by the single read port of each table.
// Clear and unknown ops walk neither table.
// Reset empties both tables at once (counts go to zero). A stalled output holds
// the request walk and the final result; a new input word is taken while the
// last result still waits.
module arp_table_with_aging_and_retry import arpt_pkg::*; #(
  parameter int unsigned ENTRIES  = ENTRIES_DEF,
  parameter int unsigned REQUESTS = REQUESTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o
);

  arpt_cmd_t  cmd;
  arpt_stat_t stat;
  logic       busy;

  // accept a word only while the sequencer sits idle
  assign in_stall_o = busy;

  arpt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_valid_i && !busy),
    .op_i    (in_word_i.op),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // tables, walk pointers, config registers and the output register
  arpt_dp #(
    .ENTRIES  (ENTRIES),
    .REQUESTS (REQUESTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

>>> hw/rtl/arpt_ctrl.sv
`default_nettype none
module arpt_ctrl import arpt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [2:0] op_i,
  input  wire arpt_stat_t stat_i,
  output arpt_cmd_t       cmd_o,
  output logic            busy_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SLOTS, ST_REQS, ST_DONE} state_e;

  state_e     state_q;
  logic [2:0] op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_TICK;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            op_q <= op_i;
            if (op_i == OP_TICK || op_i == OP_LOOKUP) begin
              state_q <= ST_SLOTS;
            end else if (op_i == OP_INSERT || op_i == OP_QUEUE || op_i == OP_REMOVE) begin
              state_q <= ST_REQS;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_SLOTS: begin
          if (stat_i.slot_end) begin
            state_q <= (op_q == OP_TICK) ? ST_REQS : ST_DONE;
          end
        end
        ST_REQS: begin
          if (stat_i.req_end) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (stat_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.start     = (state_q == ST_IDLE) && start_i;
    cmd_o.slot_step = (state_q == ST_SLOTS) && !stat_i.slot_end;
    cmd_o.slot_done = (state_q == ST_SLOTS) && stat_i.slot_end;
    cmd_o.req_step  = (state_q == ST_REQS) && !stat_i.req_end && stat_i.out_free;
    cmd_o.req_done  = (state_q == ST_REQS) && stat_i.req_end;
    cmd_o.finish    = (state_q == ST_DONE) && stat_i.out_free;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

>>> hw/rtl/arpt_dp.sv
`default_nettype none
module arpt_dp import arpt_pkg::*; #(
  parameter int unsigned ENTRIES  = ENTRIES_DEF,
  parameter int unsigned REQUESTS = REQUESTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire in_word_t    in_word_i,
  input  wire arpt_cmd_t   cmd_i,
  output arpt_stat_t       stat_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o
);

  localparam int unsigned SCW = $clog2(ENTRIES + 1);
  localparam int unsigned SIW = $clog2(ENTRIES);
  localparam int unsigned RCW = $clog2(REQUESTS + 1);
  localparam int unsigned RIW = (REQUESTS > 1) ? $clog2(REQUESTS) : 1;

  logic [31:0] slot_ip_q   [ENTRIES];
  logic [47:0] slot_mac_q  [ENTRIES];
  logic [15:0] slot_age_q  [ENTRIES];
  logic [31:0] req_ip_q    [REQUESTS];
  logic [2:0]  req_sends_q [REQUESTS];

  logic [15:0]  timeout_q;
  logic [2:0]   limit_q;
  logic [2:0]   op_q;
  logic [31:0]  ip_q;
  logic [47:0]  mac_q, hit_mac_q, hit_mac_d;
  logic         found_q, found_d;
  logic [SCW-1:0] slot_cnt_q, slot_cnt_d, sidx_q, sidx_d, swr_q, swr_d;
  logic [RCW-1:0] req_cnt_q, req_cnt_d, ridx_q, ridx_d, rwr_q, rwr_d;
  logic         out_valid_q, out_valid_d;
  out_word_t    out_q, out_d;

  logic           slot_we;
  logic [SIW-1:0] slot_wa;
  logic [31:0]    slot_wip;
  logic [47:0]    slot_wmac;
  logic [15:0]    slot_wage;
  logic           req_we;
  logic [RIW-1:0] req_wa;
  logic [31:0]    req_wip;
  logic [2:0]     req_wsends;

  logic [SIW-1:0] srd;
  logic [RIW-1:0] rrd;
  logic [16:0]    age_inc;
  logic [3:0]     sends_inc;
  logic           out_free;

  assign srd       = sidx_q[SIW-1:0];
  assign rrd       = (REQUESTS > 1) ? ridx_q[RIW-1:0] : '0;
  assign age_inc   = {1'b0, slot_age_q[srd]} + 17'd1;
  assign sends_inc = {1'b0, req_sends_q[rrd]} + 4'd1;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    stat_o.out_free = out_free;
    stat_o.slot_end = (sidx_q == slot_cnt_q) || found_q;
    stat_o.req_end  = (ridx_q == req_cnt_q) ||
                      (found_q && (op_q == OP_INSERT || op_q == OP_QUEUE));
  end

  always_comb begin
    slot_cnt_d  = slot_cnt_q;
    req_cnt_d   = req_cnt_q;
    sidx_d      = sidx_q;
    swr_d       = swr_q;
    ridx_d      = ridx_q;
    rwr_d       = rwr_q;
    found_d     = found_q;
    hit_mac_d   = hit_mac_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    slot_we     = 1'b0;
    slot_wa     = swr_q[SIW-1:0];
    slot_wip    = slot_ip_q[srd];
    slot_wmac   = slot_mac_q[srd];
    slot_wage   = age_inc[16] ? 16'hFFFF : age_inc[15:0];
    req_we      = 1'b0;
    req_wa      = (REQUESTS > 1) ? rwr_q[RIW-1:0] : '0;
    req_wip     = req_ip_q[rrd];
    req_wsends  = sends_inc[2:0];

    if (cmd_i.start) begin
      found_d = 1'b0;
      sidx_d  = '0;
      swr_d   = '0;
      ridx_d  = '0;
      rwr_d   = '0;
    end

    if (cmd_i.slot_step) begin
      sidx_d = sidx_q + 1'b1;
      if (op_q == OP_TICK) begin
        // keep the binding while its new age is within the timeout
        if (age_inc <= {1'b0, timeout_q}) begin
          slot_we = 1'b1;
          swr_d   = swr_q + 1'b1;
        end
      end else if (slot_ip_q[srd] == ip_q) begin
        found_d   = 1'b1;
        hit_mac_d = slot_mac_q[srd];
        sidx_d    = sidx_q;
      end
    end

    if (cmd_i.slot_done) begin
      if (op_q == OP_TICK) slot_cnt_d = swr_q;
      sidx_d = '0;
      swr_d  = '0;
    end

    if (cmd_i.req_step) begin
      ridx_d = ridx_q + 1'b1;
      if (op_q == OP_TICK) begin
        if (req_sends_q[rrd] < limit_q) begin
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.resend      = 1'b1;
          out_d.resend_ip   = req_ip_q[rrd];
        end
        if (sends_inc <= {1'b0, limit_q}) begin
          req_we = 1'b1;
          rwr_d  = rwr_q + 1'b1;
        end
      end else if (op_q == OP_REMOVE) begin
        if (req_ip_q[rrd] == ip_q && !found_q) begin
          found_d = 1'b1;
        end else begin
          req_we     = 1'b1;
          req_wsends = req_sends_q[rrd];
          rwr_d      = rwr_q + 1'b1;
        end
      end else if (req_ip_q[rrd] == ip_q) begin
        found_d = 1'b1;
        ridx_d  = ridx_q;
      end
    end

    if (cmd_i.req_done) begin
      if (op_q == OP_TICK || op_q == OP_REMOVE) req_cnt_d = rwr_q;
      ridx_d = '0;
      rwr_d  = '0;
    end

    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.last  = 1'b1;
      case (op_q)
        OP_LOOKUP: begin
          out_d.hit       = found_q;
          out_d.found_mac = found_q ? hit_mac_q : 48'd0;
        end
        OP_INSERT: begin
          out_d.pending = found_q;
          if (slot_cnt_q < SCW'(ENTRIES)) begin
            slot_we    = 1'b1;
            slot_wa    = slot_cnt_q[SIW-1:0];
            slot_wip   = ip_q;
            slot_wmac  = mac_q;
            slot_wage  = '0;
            slot_cnt_d = slot_cnt_q + 1'b1;
          end else begin
            out_d.table_full = 1'b1;
          end
        end
        OP_QUEUE: begin
          if (found_q) begin
            out_d.pending = 1'b1;
          end else if (req_cnt_q < RCW'(REQUESTS)) begin
            req_we     = 1'b1;
            req_wa     = (REQUESTS > 1) ? req_cnt_q[RIW-1:0] : '0;
            req_wip    = ip_q;
            req_wsends = '0;
            req_cnt_d  = req_cnt_q + 1'b1;
          end else begin
            out_d.table_full = 1'b1;
          end
        end
        OP_CLEAR: begin
          slot_cnt_d = '0;
          req_cnt_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RST;
      limit_q     <= LIMIT_RST;
      op_q        <= OP_TICK;
      found_q     <= 1'b0;
      slot_cnt_q  <= '0;
      req_cnt_q   <= '0;
      sidx_q      <= '0;
      swr_q       <= '0;
      ridx_q      <= '0;
      rwr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
          CFG_LIMIT:   limit_q   <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      if (cmd_i.start) op_q <= in_word_i.op;
      found_q     <= found_d;
      slot_cnt_q  <= slot_cnt_d;
      req_cnt_q   <= req_cnt_d;
      sidx_q      <= sidx_d;
      swr_q       <= swr_d;
      ridx_q      <= ridx_d;
      rwr_q       <= rwr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ip_q  <= in_word_i.ip_addr;
      mac_q <= in_word_i.mac_addr;
    end
    hit_mac_q <= hit_mac_d;
    out_q     <= out_d;
    if (slot_we) begin
      slot_ip_q[slot_wa]  <= slot_wip;
      slot_mac_q[slot_wa] <= slot_wmac;
      slot_age_q[slot_wa] <= slot_wage;
    end
    if (req_we) begin
      req_ip_q[req_wa]    <= req_wip;
      req_sends_q[req_wa] <= req_wsends;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_slot_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_cnt_q <= SCW'(ENTRIES) && sidx_q <= slot_cnt_q && swr_q <= sidx_q)
    else $error("slot walk pointers out of range");
  a_req_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_cnt_q <= RCW'(REQUESTS) && ridx_q <= req_cnt_q && rwr_q <= ridx_q)
    else $error("request walk pointers out of range");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(cmd_i.finish || cmd_i.req_step))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

>>> test/arp_table_with_aging_and_retry_tb.sv
module arp_table_with_aging_and_retry_tb;
  import arpt_pkg::*;

  localparam int unsigned N_SLOTS = 16;
  localparam int unsigned N_REQS  = 8;
  localparam int unsigned IDLE_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;

  arp_table_with_aging_and_retry dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the table state.
  logic [15:0] timeout_q;
  logic [2:0]  limit_q;
  logic        bind_vld [N_SLOTS];
  logic [31:0] bind_ip  [N_SLOTS];
  logic [47:0] bind_mac [N_SLOTS];
  logic [16:0] bind_age [N_SLOTS];
  logic        rq_vld   [N_REQS];
  logic [31:0] rq_ip    [N_REQS];
  logic [3:0]  rq_sends [N_REQS];

  in_word_t  word_q[$];
  out_word_t expected_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        quiet = 1'b0;  // no random idling while set

  task automatic report(input string what);
    $display("ERROR %s at %0t", what, $realtime);
    mismatches++;
  endtask

  function automatic void expect_word(input out_word_t w);
    expected_q = {expected_q, w};
  endfunction

  function automatic void add_word(input in_word_t w);
    word_q = {word_q, w};
  endfunction

  function automatic out_word_t blank();
    out_word_t w;
    w = '0;
    w.last = 1'b1;
    return w;
  endfunction

  function automatic int find_request(input logic [31:0] ip);
    for (int i = 0; i < N_REQS; i++)
      if (rq_vld[i] && rq_ip[i] == ip) return i;
    return -1;
  endfunction

  // Pack valid bindings and requests toward index zero, keeping order.
  function automatic void repack();
    int w;
    w = 0;
    for (int r = 0; r < N_SLOTS; r++) begin
      if (bind_vld[r]) begin
        bind_ip[w] = bind_ip[r]; bind_mac[w] = bind_mac[r];
        bind_age[w] = bind_age[r]; bind_vld[w] = 1'b1; w++;
      end
    end
    for (; w < N_SLOTS; w++) bind_vld[w] = 1'b0;
    w = 0;
    for (int r = 0; r < N_REQS; r++) begin
      if (rq_vld[r]) begin
        rq_ip[w] = rq_ip[r]; rq_sends[w] = rq_sends[r]; rq_vld[w] = 1'b1; w++;
      end
    end
    for (; w < N_REQS; w++) rq_vld[w] = 1'b0;
  endfunction

  // Apply one word to the shadow state and queue the results it yields.
  function automatic void resolve(input in_word_t iw);
    out_word_t o;
    logic [16:0] a;
    logic [3:0]  s;
    bit          full;
    int          k;
    o = blank();
    case (iw.op)
      OP_TICK: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (bind_vld[i]) begin
            a = bind_age[i] + 17'd1;
            if (a > {1'b0, timeout_q}) bind_vld[i] = 1'b0;
            bind_age[i] = (a > 17'hFFFF) ? 17'hFFFF : a;
          end
        end
        for (int i = 0; i < N_REQS; i++) begin
          if (rq_vld[i]) begin
            s = rq_sends[i];
            if (s < {1'b0, limit_q}) begin
              o = '0; o.resend = 1'b1; o.resend_ip = rq_ip[i];
              expect_word(o);
            end
            s++;
            if (s > {1'b0, limit_q}) rq_vld[i] = 1'b0;
            else rq_sends[i] = {1'b0, s[2:0]};
          end
        end
        repack();
        expect_word(blank());
      end
      OP_LOOKUP: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (bind_vld[i] && bind_ip[i] == iw.ip_addr) begin
            o.hit = 1'b1; o.found_mac = bind_mac[i]; break;
          end
        end
        expect_word(o);
      end
      OP_INSERT: begin
        full = 1'b1;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (!bind_vld[i]) begin
            bind_vld[i] = 1'b1; bind_ip[i] = iw.ip_addr;
            bind_mac[i] = iw.mac_addr; bind_age[i] = '0; full = 1'b0; break;
          end
        end
        o.pending = find_request(iw.ip_addr) >= 0;
        o.table_full = full;
        expect_word(o);
      end
      OP_QUEUE: begin
        if (find_request(iw.ip_addr) >= 0) o.pending = 1'b1;
        else begin
          full = 1'b1;
          for (int i = 0; i < N_REQS; i++) begin
            if (!rq_vld[i]) begin
              rq_vld[i] = 1'b1; rq_ip[i] = iw.ip_addr; rq_sends[i] = '0;
              full = 1'b0; break;
            end
          end
          o.table_full = full;
        end
        expect_word(o);
      end
      OP_REMOVE: begin
        k = find_request(iw.ip_addr);
        if (k >= 0) begin
          rq_vld[k] = 1'b0; repack();
        end
        expect_word(o);
      end
      OP_CLEAR: begin
        for (int i = 0; i < N_SLOTS; i++) bind_vld[i] = 1'b0;
        for (int i = 0; i < N_REQS; i++) rq_vld[i] = 1'b0;
        expect_word(o);
      end
      default: expect_word(o);
    endcase
  endfunction

  task automatic check_word(input out_word_t e, input out_word_t g);
    if (g.hit != e.hit) report($sformatf("hit %0b want %0b", g.hit, e.hit));
    if (g.found_mac != e.found_mac)
      report($sformatf("found_mac %h want %h", g.found_mac, e.found_mac));
    if (g.pending != e.pending) report($sformatf("pending %0b want %0b", g.pending, e.pending));
    if (g.table_full != e.table_full)
      report($sformatf("table_full %0b want %0b", g.table_full, e.table_full));
    if (g.resend != e.resend) report($sformatf("resend %0b want %0b", g.resend, e.resend));
    if (g.resend_ip != e.resend_ip)
      report($sformatf("resend_ip %h want %h", g.resend_ip, e.resend_ip));
    if (g.last != e.last) report($sformatf("last %0b want %0b", g.last, e.last));
  endtask

  // Driver: hold the word while stalled, advance on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) begin
          resolve(in_word_i);
        end
        if (word_q.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
          in_word_i  <= word_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) report("result with nothing expected");
        else check_word(expected_q.pop_front(), out_word_o);
      end
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 12);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Watchdog on cycles with no word moving.
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic in_word_t mk(input logic [2:0] op, input logic [31:0] ip,
                                  input logic [47:0] mac);
    in_word_t w;
    w.op = op; w.ip_addr = ip; w.mac_addr = mac;
    return w;
  endfunction

  // Wait until all words are through, then let the tick walk settle.
  task automatic drain();
    while (word_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (N_SLOTS + N_REQS + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_addr_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_q = val;
    else limit_q = val[2:0];
  endtask

  // Random phase: a small pool of addresses so lookups, duplicates and
  // pending requests actually meet.
  task automatic random_phase(input int count);
    logic [31:0] pool [6];
    logic [2:0]  op;
    for (int i = 0; i < 6; i++) pool[i] = $urandom();
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(99)) inside
        [0:19]:  op = OP_TICK;
        [20:39]: op = OP_LOOKUP;
        [40:64]: op = OP_INSERT;
        [65:84]: op = OP_QUEUE;
        [85:94]: op = OP_REMOVE;
        [95:97]: op = OP_CLEAR;
        default: op = 3'($urandom_range(7, 6));
      endcase
      add_word(mk(op,
        ($urandom_range(9) == 0) ? $urandom() : pool[$urandom_range(5)],
        {$urandom(), 16'($urandom())}));
    end
  endtask

  initial begin
    timeout_q = TIMEOUT_RST;
    limit_q   = LIMIT_RST;
    for (int i = 0; i < N_SLOTS; i++) begin
      bind_vld[i] = 1'b0; bind_ip[i] = '0; bind_mac[i] = '0; bind_age[i] = '0;
    end
    for (int i = 0; i < N_REQS; i++) begin
      rq_vld[i] = 1'b0; rq_ip[i] = '0; rq_sends[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every op, duplicates, pending, full tables.
    write_reg(CFG_TIMEOUT, 16'd2);
    write_reg(CFG_LIMIT, 3'd2);
    add_word(mk(OP_LOOKUP, '0, '0));
    add_word(mk(OP_QUEUE, '1, '0));
    add_word(mk(OP_QUEUE, '1, '0));
    add_word(mk(OP_INSERT, '1, '1));
    add_word(mk(OP_INSERT, '1, 48'h0123_4567_89ab));
    add_word(mk(OP_LOOKUP, '1, '0));
    add_word(mk(OP_INSERT, '0, '0));
    add_word(mk(OP_LOOKUP, '0, '1));
    for (int i = 0; i < 9; i++) add_word(mk(OP_QUEUE, 32'h0a00_0000 + i, '1));
    for (int i = 0; i < 4; i++) add_word(mk(OP_TICK, '0, '0));
    add_word(mk(OP_REMOVE, 32'hdead_beef, '0));
    add_word(mk(3'd7, '1, '1));
    add_word(mk(OP_CLEAR, '0, '0));
    drain();

    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_LIMIT, 3'd0);
    for (int i = 0; i < 17; i++) add_word(mk(OP_INSERT, i, {16'hffff, 32'(i)}));
    add_word(mk(OP_QUEUE, 32'h5, '0));
    add_word(mk(OP_REMOVE, 32'h5, '0));
    add_word(mk(OP_QUEUE, 32'h6, '0));
    add_word(mk(OP_TICK, '0, '0));
    add_word(mk(OP_TICK, '0, '0));
    add_word(mk(OP_LOOKUP, 32'h3, '0));
    drain();

    // Random phases over several settings; the first runs without idling.
    quiet = 1'b1;
    write_reg(CFG_TIMEOUT, 16'hffff);
    write_reg(CFG_LIMIT, 3'd7);
    random_phase(25);
    drain();
    quiet = 1'b0;
    write_reg(CFG_TIMEOUT, 16'd4);
    write_reg(CFG_LIMIT, 3'd3);
    random_phase(30);
    drain();
    write_reg(CFG_TIMEOUT, 16'd30);
    write_reg(CFG_LIMIT, 3'd1);
    random_phase(30);
    drain();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/arpt_pkg.sv
hw/rtl/arpt_ctrl.sv
hw/rtl/arpt_dp.sv
hw/rtl/arp_table_with_aging_and_retry.sv
test/arp_table_with_aging_and_retry_tb.sv
